FILE: design/bprq_pkg.sv
`default_nettype none
package bprq_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int FREQ_W   = 16;
   localparam int COUNT_W  = 8;
   localparam int LOUD_W   = 9;
   localparam int RLOUD_W  = 10;
   localparam int TICKS_W  = 8;
   localparam int LEVEL_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // Q8 loudness, 256 = 1.0
   localparam logic [LOUD_W-1:0] Q8_ONE = 9'd256;

   // Register reset values
   localparam logic [TICKS_W-1:0] RST_ON_TICKS     = 8'd8;
   localparam logic [TICKS_W-1:0] RST_OFF_TICKS    = 8'd8;
   localparam logic [LOUD_W-1:0]  RST_DEFAULT_LOUD = 9'd77;
   localparam logic [COUNT_W-1:0] RST_MAX_COUNT    = 8'd6;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ON_TICKS     = 2'd0,
      CSR_OFF_TICKS    = 2'd1,
      CSR_DEFAULT_LOUD = 2'd2,
      CSR_MAX_COUNT    = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_TICK    = 1'b0,
      OP_REQUEST = 1'b1
   } op_type;

   typedef struct packed {
      logic                 op;
      logic [FREQ_W-1:0]    req_frequency;
      logic [COUNT_W-1:0]   req_count;
      logic [RLOUD_W-1:0]   req_loudness;
   } req_payload_type;

   typedef struct packed {
      logic                 accepted;
      logic                 sequencing;
      logic                 tone_on;
      logic [FREQ_W-1:0]    tone_frequency;
      logic [LOUD_W-1:0]    tone_loudness;
      logic [LEVEL_W-1:0]   queue_level;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_payload_type;

   // One queued request
   typedef struct packed {
      logic [FREQ_W-1:0]  freq;
      logic [COUNT_W-1:0] count;
      logic [LOUD_W-1:0]  loud;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_FETCH = 2'd1,
      ST_HOLD  = 2'd2
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic exec;   // run the accepted transaction directly
      logic pop;    // start the next queued beep from the read data
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic pop_needed;
   } status_type;

endpackage
`default_nettype wire

FILE: design/bprq_channels.sv
`default_nettype none
interface bprq_req_if;
   logic                      valid;
   logic                      ready;
   bprq_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bprq_rsp_if;
   logic                      valid;
   logic                      ready;
   bprq_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bprq_csr_if;
   logic                      valid;
   logic                      ready;
   bprq_pkg::csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: design/bprq_ctrl.sv
`default_nettype none
module bprq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire bprq_pkg::status_type status,
   output bprq_pkg::cmd_type         cmd
);

   bprq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bprq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bprq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.pop_needed ? bprq_pkg::ST_FETCH : bprq_pkg::ST_HOLD;
            end
         end
         bprq_pkg::ST_FETCH: begin
            state_in = bprq_pkg::ST_HOLD;
         end
         bprq_pkg::ST_HOLD: begin
            if (rsp_ready) begin
               state_in = bprq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bprq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         bprq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.exec  = req_valid & ~status.pop_needed;
         end
         bprq_pkg::ST_FETCH: begin
            cmd.pop = 1'b1;
         end
         bprq_pkg::ST_HOLD: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: design/bprq_datapath.sv
`default_nettype none
module bprq_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire bprq_pkg::req_payload_type req_payload,
   output bprq_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                      csr_write,
   input  wire bprq_pkg::csr_payload_type csr_payload,
   input  wire bprq_pkg::cmd_type         cmd,
   output bprq_pkg::status_type           status
);

   // Configuration
   logic [bprq_pkg::TICKS_W-1:0] on_ticks_ff, off_ticks_ff;
   logic [bprq_pkg::LOUD_W-1:0]  default_loud_ff;
   logic [bprq_pkg::COUNT_W-1:0] max_count_ff;

   // Queue
   bprq_pkg::entry_type              store [bprq_pkg::QUEUE_DEPTH];
   bprq_pkg::entry_type              rd_data_ff;
   logic [bprq_pkg::PTR_W-1:0]       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [bprq_pkg::FILL_W-1:0]      fill_ff, fill_in;

   // Sequencer
   logic [bprq_pkg::FREQ_W-1:0]  freq_ff, freq_in;
   logic [bprq_pkg::LOUD_W-1:0]  loud_ff, loud_in;
   logic [bprq_pkg::COUNT_W-1:0] beeps_ff, beeps_in;
   logic [bprq_pkg::TICKS_W-1:0] phase_ff, phase_in;
   logic                         phase_on_ff, phase_on_in;
   logic                         enable_ff, enable_in;

   // Result flags
   logic accepted_ff, accepted_in, sequencing_ff, sequencing_in;

   // Request shaping
   logic                            req_ok;
   logic                            wr_en;
   logic [bprq_pkg::COUNT_W-1:0]    max_eff, count_clamped, beeps_dec;
   logic [bprq_pkg::RLOUD_W-1:0]    loud_pick;
   bprq_pkg::entry_type             wr_entry;
   logic [bprq_pkg::TICKS_W-1:0]    phase_dec;
   logic [bprq_pkg::FILL_W+3:0]     fill_ext;

   assign status.pop_needed = (req_payload.op == bprq_pkg::OP_TICK) &&
                              (beeps_ff == '0) && (fill_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ticks_ff     <= bprq_pkg::RST_ON_TICKS;
         off_ticks_ff    <= bprq_pkg::RST_OFF_TICKS;
         default_loud_ff <= bprq_pkg::RST_DEFAULT_LOUD;
         max_count_ff    <= bprq_pkg::RST_MAX_COUNT;
      end else if (csr_write) begin
         case (csr_payload.index)
            bprq_pkg::CSR_ON_TICKS:     on_ticks_ff     <= csr_payload.data[bprq_pkg::TICKS_W-1:0];
            bprq_pkg::CSR_OFF_TICKS:    off_ticks_ff    <= csr_payload.data[bprq_pkg::TICKS_W-1:0];
            bprq_pkg::CSR_DEFAULT_LOUD: default_loud_ff <= csr_payload.data[bprq_pkg::LOUD_W-1:0];
            bprq_pkg::CSR_MAX_COUNT:    max_count_ff    <= csr_payload.data[bprq_pkg::COUNT_W-1:0];
            default:                    max_count_ff    <= max_count_ff;
         endcase
      end
   end

   always_comb begin
      req_ok = (req_payload.req_frequency != '0) && (req_payload.req_count != '0) &&
               (fill_ff < bprq_pkg::FILL_W'(bprq_pkg::QUEUE_DEPTH));
      max_eff = (max_count_ff == '0) ? bprq_pkg::COUNT_W'(1) : max_count_ff;
      count_clamped = (req_payload.req_count > max_eff) ? max_eff : req_payload.req_count;
      loud_pick = (req_payload.req_loudness == '0) ? {1'b0, default_loud_ff}
                                                   : req_payload.req_loudness;
      wr_entry.freq  = req_payload.req_frequency;
      wr_entry.count = count_clamped;
      wr_entry.loud  = (loud_pick > {1'b0, bprq_pkg::Q8_ONE}) ? bprq_pkg::Q8_ONE
                                                               : loud_pick[bprq_pkg::LOUD_W-1:0];
      wr_en = cmd.exec && (req_payload.op == bprq_pkg::OP_REQUEST) && req_ok;
   end

   // Queue memory: one write port, registered read at the read pointer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_ptr_ff] <= wr_entry;
      end
      rd_data_ff <= store[rd_ptr_ff];
   end

   always_comb begin
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      fill_in       = fill_ff;
      freq_in       = freq_ff;
      loud_in       = loud_ff;
      beeps_in      = beeps_ff;
      phase_in      = phase_ff;
      phase_on_in   = phase_on_ff;
      enable_in     = enable_ff;
      accepted_in   = accepted_ff;
      sequencing_in = sequencing_ff;
      phase_dec     = (phase_ff != '0) ? phase_ff - 1'b1 : '0;
      beeps_dec     = beeps_ff - 1'b1;

      if (cmd.pop) begin
         // Start the first beep of the next queued request
         rd_ptr_in     = (rd_ptr_ff == bprq_pkg::PTR_W'(bprq_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + 1'b1;
         fill_in       = fill_ff - 1'b1;
         freq_in       = rd_data_ff.freq;
         loud_in       = rd_data_ff.loud;
         beeps_in      = rd_data_ff.count;
         phase_on_in   = 1'b1;
         phase_in      = on_ticks_ff;
         enable_in     = 1'b1;
         accepted_in   = 1'b0;
         sequencing_in = 1'b1;
      end else if (cmd.exec) begin
         if (req_payload.op == bprq_pkg::OP_REQUEST) begin
            accepted_in   = req_ok;
            sequencing_in = 1'b0;
            if (req_ok) begin
               wr_ptr_in = (wr_ptr_ff == bprq_pkg::PTR_W'(bprq_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + 1'b1;
               fill_in   = fill_ff + 1'b1;
            end
         end else begin
            accepted_in   = 1'b0;
            sequencing_in = (beeps_ff != '0);
            if (beeps_ff != '0) begin
               phase_in = phase_dec;
               if (phase_dec == '0) begin
                  if (phase_on_ff) begin
                     // End of the on phase: go silent
                     phase_on_in = 1'b0;
                     phase_in    = off_ticks_ff;
                     enable_in   = 1'b0;
                  end else begin
                     beeps_in = beeps_dec;
                     if (beeps_dec == '0) begin
                        enable_in = 1'b0;
                     end else begin
                        phase_on_in = 1'b1;
                        phase_in    = on_ticks_ff;
                        enable_in   = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         fill_ff       <= '0;
         freq_ff       <= '0;
         loud_ff       <= bprq_pkg::RST_DEFAULT_LOUD;
         beeps_ff      <= '0;
         phase_ff      <= '0;
         phase_on_ff   <= 1'b0;
         enable_ff     <= 1'b0;
         accepted_ff   <= 1'b0;
         sequencing_ff <= 1'b0;
      end else begin
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         fill_ff       <= fill_in;
         freq_ff       <= freq_in;
         loud_ff       <= loud_in;
         beeps_ff      <= beeps_in;
         phase_ff      <= phase_in;
         phase_on_ff   <= phase_on_in;
         enable_ff     <= enable_in;
         accepted_ff   <= accepted_in;
         sequencing_ff <= sequencing_in;
      end
   end

   assign fill_ext = {4'b0000, fill_ff};

   always_comb begin
      rsp_payload.accepted       = accepted_ff;
      rsp_payload.sequencing     = sequencing_ff;
      rsp_payload.tone_on        = enable_ff;
      rsp_payload.tone_frequency = freq_ff;
      rsp_payload.tone_loudness  = loud_ff;
      rsp_payload.queue_level    = fill_ext[bprq_pkg::LEVEL_W-1:0];
   end

endmodule
`default_nettype wire

FILE: design/beep_request_queue_sequencer.sv
`default_nettype none
// Beep request queue and on/off tone sequencer. Each transaction on req_if is
// either a tick (op 0) or a beep request (op 1); every one produces exactly one
// transaction on rsp_if reporting whether a request was queued, whether the tick
// was handled by the sequencer, and the tone state and queue level afterwards.
// One transaction is in flight at a time. A request or a plain tick updates the
// result registers at the edge that accepts it, so rsp_valid rises right after
// that edge. A tick that starts the next queued beep first passes through a
// fetch state that takes the entry from the registered read port of the queue
// memory, and its result registers update at the end of that state. req_ready
// rises right after the edge that takes the result, and rsp_valid stays high
// while rsp_ready is low. Registers on csr_if (on_ticks, off_ticks,
// default_loudness, max_count) are always ready and must be written only
// while no transaction is outstanding.
module beep_request_queue_sequencer (
   input  wire logic    clock,
   input  wire logic    reset,
   bprq_req_if.sink     req_if,
   bprq_rsp_if.source   rsp_if,
   bprq_csr_if.sink     csr_if
);

   bprq_pkg::cmd_type    cmd;
   bprq_pkg::status_type status;

   // Configuration writes are taken every cycle
   assign csr_if.ready = 1'b1;

   // Controller: handshakes and sequencing of the memory read
   bprq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: queue memory, sequencer counters, config registers
   bprq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_if.payload),
      .rsp_payload (rsp_if.payload),
      .csr_write   (csr_if.valid & csr_if.ready),
      .csr_payload (csr_if.payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
`default_nettype wire
